### rtl/salc_pkg.sv
// Shared types, constants and helper functions of the LRU cache model unit.
// No dependencies; used by salc_way_sel, set_assoc_lru_cache_sim_unit and its testbench.
package salc_pkg;

  localparam int ADDR_W   = 32;
  localparam int TAG_W    = 30;
  localparam int STAMP_W  = 32;
  localparam int CNT_W    = 32;
  localparam int ADD_W    = 2;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;
  // one stored line: valid in bit 0, then tag, then recency stamp
  localparam int ENTRY_W  = 1 + TAG_W + STAMP_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 104;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  // outcome of one set lookup
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

  // saturating add of a small per-request count
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [ADD_W-1:0] add);
    logic [CNT_W:0] sum;
    sum = {1'b0, cnt} + {{(CNT_W + 1 - ADD_W){1'b0}}, add};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

### rtl/salc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/salc_way_sel.sv
// Way selection of one set: tag match, first free way, and LRU victim tree.
// Depends on salc_pkg.
module salc_way_sel #(
  parameter int MAX_WAYS = 8
) (
  input  logic [MAX_WAYS-1:0]                  valid_i,
  input  logic [MAX_WAYS-1:0]                  in_use_i,
  input  logic [MAX_WAYS*salc_pkg::TAG_W-1:0]   tags_i,
  input  logic [MAX_WAYS*salc_pkg::STAMP_W-1:0] stamps_i,
  input  logic [salc_pkg::TAG_W-1:0]            tag_i,
  output salc_pkg::lookup_t                     look_o,
  output logic [MAX_WAYS-1:0]                  sel_o
);
  import salc_pkg::*;

  localparam int LVL = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
  localparam int N   = 1 << LVL;
  localparam int IW  = (LVL > 0) ? LVL : 1;

  logic [MAX_WAYS-1:0] hit_oh;
  logic [MAX_WAYS-1:0] free_oh;
  logic [MAX_WAYS-1:0] victim_oh;
  logic                any_hit;
  logic                any_free;
  logic [STAMP_W:0]    key  [2*N];
  logic [IW-1:0]       kidx [2*N];

  // first matching way and first free way among those in use
  always_comb begin
    any_hit  = 1'b0;
    any_free = 1'b0;
    hit_oh   = '0;
    free_oh  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use_i[i] && valid_i[i] && tags_i[i*TAG_W +: TAG_W] == tag_i && !any_hit) begin
        hit_oh[i] = 1'b1;
        any_hit   = 1'b1;
      end
      if (in_use_i[i] && !valid_i[i] && !any_free) begin
        free_oh[i] = 1'b1;
        any_free   = 1'b1;
      end
    end
  end

  // min tree over stamps; ways not in use carry a high flag and never win,
  // on equal keys the lower way is kept
  always_comb begin
    key[0]  = '0;
    kidx[0] = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      key[N+j]  = {~in_use_i[j], stamps_i[j*STAMP_W +: STAMP_W]};
      kidx[N+j] = IW'(j);
    end
    for (int j = MAX_WAYS; j < N; j++) begin
      key[N+j]  = {1'b1, {STAMP_W{1'b1}}};
      kidx[N+j] = IW'(j);
    end
    for (int j = N - 1; j >= 1; j--) begin
      if (key[2*j+1] < key[2*j]) begin
        key[j]  = key[2*j+1];
        kidx[j] = kidx[2*j+1];
      end else begin
        key[j]  = key[2*j];
        kidx[j] = kidx[2*j];
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      victim_oh[i] = (kidx[1] == IW'(i));
    end
  end

  // final choice
  always_comb begin
    look_o.hit   = any_hit;
    look_o.evict = !any_hit && !any_free;
    if (any_hit) begin
      sel_o = hit_oh;
    end else if (any_free) begin
      sel_o = free_oh;
    end else begin
      sel_o = victim_oh;
    end
  end

endmodule

### rtl/set_assoc_lru_cache_sim_unit.sv
// Set-associative LRU cache model: counts hits, misses and evictions per request.
// A request accepted in idle is resolved in the lookup state, which loads its result into the output
// register and is left only once the previous result is no longer waiting in the output register.
// No new request is taken until the read-modify-write of the set memory for the last one is done.
// A modify is resolved in the same pass: its second access always hits the same line.
// Reset: counters and access clock cleared, one valid flop per set marks it empty,
// so the cache is usable right after reset without a clearing pass.
// Depends on salc_pkg, salc_ram and salc_way_sel.
module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [salc_pkg::CFG_W-1:0]         cfg_data_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] cmd, [33:2] address, [39:34] zero
  input  logic [salc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] hits_added, [3:2] misses_added, [5:4] evictions_added,
  // [37:6] hit_total, [69:38] miss_total, [101:70] eviction_total, [103:102] zero
  output logic [salc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import salc_pkg::*;

  localparam int SET_W  = MAX_SET_BITS;
  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int ROW_W  = MAX_WAYS * ENTRY_W;
  // effective set bit count, 4 bits cover the parameter range up to 15
  localparam int SEFF_W = 4;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e              state_q, state_d;
  logic [2:0]          set_bits_q, set_bits_d;
  logic [4:0]          block_bits_q, block_bits_d;
  logic [3:0]          ways_q, ways_d;
  logic [STAMP_W-1:0]  clock_q, clock_d;
  logic [CNT_W-1:0]    hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]    miss_cnt_q, miss_cnt_d;
  logic [CNT_W-1:0]    evict_cnt_q, evict_cnt_d;
  logic [SETS-1:0]     row_init_q, row_init_d;
  logic                out_valid_q, out_valid_d;
  logic [ADD_W-1:0]    hits_add_q, hits_add_d;
  logic [ADD_W-1:0]    miss_add_q, miss_add_d;
  logic [ADD_W-1:0]    evict_add_q, evict_add_d;
  logic [SET_W-1:0]    set_q;
  logic [TAG_W-1:0]    tag_q;
  cmd_e                cmd_q;

  logic                accept;
  logic                done;
  logic                is_access;
  logic [ADDR_W-1:0]   addr;
  logic [4:0]          b_eff;
  logic [SEFF_W-1:0]   s_eff;
  logic [SET_W-1:0]    set_mask;
  logic [SET_W-1:0]    set_c;
  logic [TAG_W-1:0]    tag_c;
  logic [5:0]          tag_shift;
  int                  w_eff;
  logic [MAX_WAYS-1:0] in_use;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    wr_row;
  logic [MAX_WAYS-1:0] valid_vec;
  logic [MAX_WAYS*TAG_W-1:0]   tags_vec;
  logic [MAX_WAYS*STAMP_W-1:0] stamps_vec;
  logic [MAX_WAYS-1:0] sel_oh;
  lookup_t             look;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign done          = (state_q == ST_LOOK) && (!out_valid_q || m_axis_tready);
  assign addr          = s_axis_tdata[ADDR_W+1:2];

  // clamp registers into their legal ranges
  always_comb begin
    if (block_bits_q == 5'd0) begin
      b_eff = 5'd1;
    end else if (block_bits_q > 5'd16) begin
      b_eff = 5'd16;
    end else begin
      b_eff = block_bits_q;
    end
    if (set_bits_q == 3'd0) begin
      s_eff = SEFF_W'(1);
    end else if (int'(set_bits_q) > MAX_SET_BITS) begin
      s_eff = SEFF_W'(MAX_SET_BITS);
    end else begin
      s_eff = SEFF_W'(set_bits_q);
    end
    if (ways_q == 4'd0) begin
      w_eff = 1;
    end else if (int'(ways_q) > MAX_WAYS) begin
      w_eff = MAX_WAYS;
    end else begin
      w_eff = int'(ways_q);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (i < w_eff);
    end
  end

  // address split into set index and tag
  assign set_mask  = ~({SET_W{1'b1}} << s_eff);
  assign set_c     = SET_W'(addr >> b_eff) & set_mask;
  assign tag_shift = 6'(b_eff) + 6'(s_eff);
  assign tag_c     = TAG_W'(addr >> tag_shift);

  // set memory: all ways of one set in a row
  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_set_ram (
    .clk_i  (clk_i),
    .we_i   (done && is_access),
    .waddr_i(set_q),
    .wdata_i(wr_row),
    .re_i   (accept),
    .raddr_i(set_c),
    .rdata_o(rd_row)
  );

  // unpack the row; a set never written reads as empty
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      valid_vec[i] = row_init_q[set_q] && rd_row[i*ENTRY_W];
      tags_vec[i*TAG_W +: TAG_W]       = rd_row[i*ENTRY_W + 1 +: TAG_W];
      stamps_vec[i*STAMP_W +: STAMP_W] = rd_row[i*ENTRY_W + 1 + TAG_W +: STAMP_W];
    end
  end

  salc_way_sel #(
    .MAX_WAYS(MAX_WAYS)
  ) u_way_sel (
    .valid_i (valid_vec),
    .in_use_i(in_use),
    .tags_i  (tags_vec),
    .stamps_i(stamps_vec),
    .tag_i   (tag_q),
    .look_o  (look),
    .sel_o   (sel_oh)
  );

  // updated row: chosen way gets tag and current stamp
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (sel_oh[i]) begin
        wr_row[i*ENTRY_W +: ENTRY_W] = {clock_q, tag_q, 1'b1};
      end else begin
        wr_row[i*ENTRY_W +: ENTRY_W] = {stamps_vec[i*STAMP_W +: STAMP_W],
                                        tags_vec[i*TAG_W +: TAG_W], valid_vec[i]};
      end
    end
  end

  // request decode
  always_comb begin
    unique case (cmd_q) inside
      CMD_LOAD, CMD_STORE, CMD_MODIFY: is_access = 1'b1;
      default:                         is_access = 1'b0;
    endcase
  end

  // next-state logic
  always_comb begin
    state_d      = state_q;
    set_bits_d   = set_bits_q;
    block_bits_d = block_bits_q;
    ways_d       = ways_q;
    clock_d      = clock_q;
    hit_cnt_d    = hit_cnt_q;
    miss_cnt_d   = miss_cnt_q;
    evict_cnt_d  = evict_cnt_q;
    row_init_d   = row_init_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    hits_add_d   = hits_add_q;
    miss_add_d   = miss_add_q;
    evict_add_d  = evict_add_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SET_BITS:   set_bits_d   = cfg_data_i[2:0];
        REG_BLOCK_BITS: block_bits_d = cfg_data_i;
        REG_WAYS:       ways_d       = cfg_data_i[3:0];
        default:        ;
      endcase
    end

    if (accept) begin
      state_d = ST_LOOK;
    end

    if (done) begin
      state_d     = ST_IDLE;
      out_valid_d = 1'b1;
      clock_d     = clock_q + 1'b1;
      hits_add_d  = '0;
      miss_add_d  = '0;
      evict_add_d = '0;
      if (is_access) begin
        row_init_d[set_q] = 1'b1;
        hits_add_d  = ADD_W'(look.hit) + ADD_W'(cmd_q == CMD_MODIFY);
        miss_add_d  = ADD_W'(!look.hit);
        evict_add_d = ADD_W'(look.evict);
      end
      hit_cnt_d   = sat_add(hit_cnt_q, hits_add_d);
      miss_cnt_d  = sat_add(miss_cnt_q, miss_add_d);
      evict_cnt_d = sat_add(evict_cnt_q, evict_add_d);
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      set_bits_q   <= 3'd4;
      block_bits_q <= 5'd4;
      ways_q       <= 4'd1;
      clock_q      <= '0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      evict_cnt_q  <= '0;
      row_init_q   <= '0;
      out_valid_q  <= 1'b0;
      hits_add_q   <= '0;
      miss_add_q   <= '0;
      evict_add_q  <= '0;
    end else begin
      state_q      <= state_d;
      set_bits_q   <= set_bits_d;
      block_bits_q <= block_bits_d;
      ways_q       <= ways_d;
      clock_q      <= clock_d;
      hit_cnt_q    <= hit_cnt_d;
      miss_cnt_q   <= miss_cnt_d;
      evict_cnt_q  <= evict_cnt_d;
      row_init_q   <= row_init_d;
      out_valid_q  <= out_valid_d;
      hits_add_q   <= hits_add_d;
      miss_add_q   <= miss_add_d;
      evict_add_q  <= evict_add_d;
    end
  end

  // request payload held for the lookup state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_c;
      tag_q <= tag_c;
      cmd_q <= cmd_e'(s_axis_tdata[1:0]);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, evict_cnt_q, miss_cnt_q, hit_cnt_q,
                          evict_add_q, miss_add_q, hits_add_q};

  // a request always goes to the lookup state next
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOK)
    else $error("accepted request did not enter lookup");

  // a real access updates exactly one way
  a_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && is_access) |-> $onehot(sel_oh))
    else $error("write-back does not select exactly one way");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK && look.hit) |-> !look.evict)
    else $error("hit flagged together with eviction");

  // hit total never goes backward; eviction total stays within miss total unless misses saturate
  a_totals_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (hit_cnt_q >= $past(hit_cnt_q)) && (evict_cnt_q <= miss_cnt_q
              || $past(evict_cnt_q) > $past(miss_cnt_q) || miss_cnt_q == '1))
    else $error("running totals inconsistent");

endmodule

### tb/set_assoc_lru_cache_sim_unit_tb.sv
// Self-checking testbench of the set-associative LRU cache model unit.
// Predicts hit, miss and eviction counts per request and checks every result.
// Depends on salc_pkg and the set_assoc_lru_cache_sim_unit RTL.
module set_assoc_lru_cache_sim_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import salc_pkg::*;

  localparam int SET_BITS_MAX   = 6;
  localparam int WAYS_MAX       = 8;
  localparam int LINE_TOTAL     = (1 << SET_BITS_MAX) * WAYS_MAX;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int BATCH_ACCESSES = 102;
  localparam int MAX_ERR_LINES  = 100;
  // command code outside the enum: no access is made
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;

  // counts of one request plus the running totals
  typedef struct packed {
    logic [ADD_W-1:0] hits;
    logic [ADD_W-1:0] misses;
    logic [ADD_W-1:0] evictions;
    logic [CNT_W-1:0] hit_sum;
    logic [CNT_W-1:0] miss_sum;
    logic [CNT_W-1:0] evict_sum;
  } cache_tally_t;

  cache_tally_t tally_queue[$];

  // predicted cache contents and counters
  logic               line_valid_q [LINE_TOTAL];
  logic [TAG_W-1:0]   line_tag_q   [LINE_TOTAL];
  logic [STAMP_W-1:0] line_stamp_q [LINE_TOTAL];
  logic [STAMP_W-1:0] access_tick;
  logic [CNT_W-1:0]   hit_sum_q;
  logic [CNT_W-1:0]   miss_sum_q;
  logic [CNT_W-1:0]   evict_sum_q;
  int unsigned        item_hits;
  int unsigned        item_misses;
  int unsigned        item_evictions;

  // register values as written, clamped on use
  logic [2:0] set_bits_reg;
  logic [4:0] block_bits_reg;
  logic [3:0] ways_reg;

  int unsigned send_idle_pct  = 15;
  int unsigned recv_stall_pct = 61;
  int unsigned err_count      = 0;
  int unsigned idle_cycles;

  // settings of the random part: set bits, block bits, ways (some out of range)
  int unsigned cfg_plan [9][3] = '{
    '{1, 1, 1}, '{6, 16, 8}, '{3, 5, 4},
    '{2, 12, 2}, '{0, 20, 12}, '{4, 4, 3},
    '{6, 1, 7}, '{1, 16, 5}, '{7, 31, 15}
  };

  set_assoc_lru_cache_sim_unit #(
    .MAX_SET_BITS(SET_BITS_MAX),
    .MAX_WAYS    (WAYS_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_range(input int unsigned v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_set_bits();
    return clamp_range(set_bits_reg, 1, SET_BITS_MAX);
  endfunction

  function automatic int unsigned eff_block_bits();
    return clamp_range(block_bits_reg, 1, 16);
  endfunction

  function automatic int unsigned eff_ways();
    return clamp_range(ways_reg, 1, WAYS_MAX);
  endfunction

  function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] cnt);
    return (cnt == '1) ? cnt : cnt + 1'b1;
  endfunction

  function automatic void clear_cache_model();
    for (int i = 0; i < LINE_TOTAL; i++) begin
      line_valid_q[i] = 1'b0;
      line_tag_q[i]   = '0;
      line_stamp_q[i] = '0;
    end
    access_tick    = '0;
    hit_sum_q      = '0;
    miss_sum_q     = '0;
    evict_sum_q    = '0;
    set_bits_reg   = 3'd4;
    block_bits_reg = 5'd4;
    ways_reg       = 4'd1;
  endfunction

  // one cache access: lookup, then fill or evict the least recently used way
  function automatic void touch_line(input logic [ADDR_W-1:0] addr);
    int unsigned s;
    int unsigned b;
    int unsigned w;
    int unsigned base;
    int unsigned victim;
    logic [ADDR_W-1:0]  set_idx;
    logic [ADDR_W-1:0]  tag_v;
    logic [STAMP_W-1:0] oldest;
    s = eff_set_bits();
    b = eff_block_bits();
    w = eff_ways();
    set_idx = (addr >> b) & ((32'd1 << s) - 1);
    tag_v = addr >> (b + s);
    base = set_idx * WAYS_MAX;
    for (int i = 0; i < w; i++) begin
      if (line_valid_q[base + i] && line_tag_q[base + i] == tag_v[TAG_W-1:0]) begin
        item_hits++;
        hit_sum_q = bump_count(hit_sum_q);
        line_stamp_q[base + i] = access_tick;
        return;
      end
    end
    item_misses++;
    miss_sum_q = bump_count(miss_sum_q);
    for (int i = 0; i < w; i++) begin
      if (!line_valid_q[base + i]) begin
        line_valid_q[base + i] = 1'b1;
        line_tag_q[base + i]   = tag_v[TAG_W-1:0];
        line_stamp_q[base + i] = access_tick;
        return;
      end
    end
    item_evictions++;
    evict_sum_q = bump_count(evict_sum_q);
    // smallest stamp wins, lowest way on a tie
    victim = 0;
    oldest = line_stamp_q[base];
    for (int i = 1; i < w; i++) begin
      if (line_stamp_q[base + i] < oldest) begin
        oldest = line_stamp_q[base + i];
        victim = i;
      end
    end
    line_tag_q[base + victim]   = tag_v[TAG_W-1:0];
    line_stamp_q[base + victim] = access_tick;
  endfunction

  // expected result of one accepted request
  function automatic void predict_request(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
    cache_tally_t tally;
    item_hits      = 0;
    item_misses    = 0;
    item_evictions = 0;
    case (cmd)
      CMD_LOAD, CMD_STORE: begin
        touch_line(addr);
      end
      CMD_MODIFY: begin
        touch_line(addr);
        touch_line(addr);
      end
      default: ;
    endcase
    access_tick = access_tick + 1'b1;
    tally.hits      = item_hits[ADD_W-1:0];
    tally.misses    = item_misses[ADD_W-1:0];
    tally.evictions = item_evictions[ADD_W-1:0];
    tally.hit_sum   = hit_sum_q;
    tally.miss_sum  = miss_sum_q;
    tally.evict_sum = evict_sum_q;
    tally_queue.push_back(tally);
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_ERR_LINES) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [CNT_W-1:0] want, got);
    if (want !== got) report_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    cache_tally_t want;
    if (tally_queue.size() == 0) begin
      report_error("result with no request pending");
      return;
    end
    want = tally_queue.pop_front();
    compare_field("hits_added", want.hits, data[1:0]);
    compare_field("misses_added", want.misses, data[3:2]);
    compare_field("evictions_added", want.evictions, data[5:4]);
    compare_field("hit_total", want.hit_sum, data[37:6]);
    compare_field("miss_total", want.miss_sum, data[69:38]);
    compare_field("eviction_total", want.evict_sum, data[101:70]);
  endtask

  // send one request; tvalid stays high into the next call unless it idles
  task automatic send_request(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - ADDR_W - 2){1'b0}}, addr, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(cmd, addr);
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tally_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    case (idx)
      REG_SET_BITS:   set_bits_reg   = value[2:0];
      REG_BLOCK_BITS: block_bits_reg = value[4:0];
      REG_WAYS:       ways_reg       = value[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned set_v, block_v, ways_v);
    wait_idle();
    write_reg(REG_SET_BITS, set_v);
    write_reg(REG_BLOCK_BITS, block_v);
    write_reg(REG_WAYS, ways_v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // reset settings: one way, 16 sets, 16-byte blocks
  task automatic test_reset_config();
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_LOAD, 32'h0000_0004);
    send_request(CMD_STORE, 32'hFFFF_FFFF);
    send_request(CMD_MODIFY, 32'h0000_0100);
    send_request(CMD_NONE, 32'h1234_5678);
    send_request(CMD_LOAD, 32'h0000_0000);
  endtask

  // register values below and above their ranges
  task automatic test_register_extremes();
    configure(0, 0, 0);
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_STORE, 32'hFFFF_FFFF);
    send_request(CMD_MODIFY, 32'h0000_0002);
    configure(7, 31, 15);
  endtask

  // eight ways of one set filled, then replacement order and a shrink of ways
  task automatic test_lru_order();
    logic [ADDR_W-1:0] set_part;
    set_part = (32'd5 << 16) | 32'hABCD;
    for (int t = 0; t < 8; t++) send_request(CMD_LOAD, (t << 22) | set_part);
    send_request(CMD_LOAD, set_part);
    send_request(CMD_STORE, (32'd8 << 22) | set_part);
    send_request(CMD_MODIFY, (32'd1 << 22) | set_part);
    send_request(CMD_LOAD, (32'd2 << 22) | set_part);
    // fewer ways without a flush: upper ways are left alone
    configure(6, 16, 2);
    send_request(CMD_LOAD, set_part);
    send_request(CMD_LOAD, (32'd8 << 22) | set_part);
    send_request(CMD_LOAD, (32'd4 << 22) | set_part);
  endtask

  // mostly a small pool of tags over a few sets, some fully random addresses
  task automatic run_random_batch(input int unsigned n_access);
    logic [ADDR_W-1:0] tag_pool [16];
    logic [ADDR_W-1:0] addr;
    logic [1:0]        cmd;
    int unsigned s;
    int unsigned b;
    int unsigned pool_n;
    int unsigned set_span;
    int unsigned done;
    s = eff_set_bits();
    b = eff_block_bits();
    pool_n = eff_ways() + 2;
    for (int i = 0; i < pool_n; i++) tag_pool[i] = $urandom();
    done = 0;
    while (done < n_access) begin
      if ($urandom_range(99) < 5) cmd = CMD_NONE;
      else cmd = 2'($urandom_range(2));
      if ($urandom_range(99) < 15) begin
        addr = $urandom();
      end else begin
        set_span = (1 << s) - 1;
        if (set_span > 3 && $urandom_range(99) < 80) set_span = 3;
        addr = (tag_pool[$urandom_range(pool_n - 1)] << (b + s))
             | ($urandom_range(set_span) << b)
             | ($urandom() & ((32'd1 << b) - 1));
      end
      send_request(cmd, addr);
      if (cmd != CMD_NONE) done++;
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, stall_pct, first_plan);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 3; k++) begin
      configure(cfg_plan[first_plan + k][0], cfg_plan[first_plan + k][1],
                cfg_plan[first_plan + k][2]);
      run_random_batch(BATCH_ACCESSES);
    end
  endtask

  // result side: check accepted results, stall at random
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake and no register write
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL set_assoc_lru_cache_sim_unit");
    $finish;
  end

  // main sequence
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_SET_BITS;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    clear_cache_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_register_extremes();
    test_lru_order();
    test_random_traffic(15, 61, 0);
    test_random_traffic(61, 15, 3);
    test_random_traffic(0, 0, 6);
    wait_idle();
    if (err_count == 0) begin
      $display("PASS set_assoc_lru_cache_sim_unit");
    end else begin
      $display("FAIL set_assoc_lru_cache_sim_unit");
    end
    $finish;
  end

endmodule

### files.f
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_way_sel.sv
rtl/set_assoc_lru_cache_sim_unit.sv
tb/set_assoc_lru_cache_sim_unit_tb.sv
